### src/fee_pkg.sv
// fee_pkg: shared codes, header bytes and controller/datapath command types
// for the two-sector flash EEPROM emulation controller. No dependencies.
package fee_pkg;

    localparam logic [7:0] HDR_LIVE    = 8'h5F;
    localparam logic [7:0] HDR_FREE    = 8'hFF;
    localparam logic [7:0] HDR_RETIRED = 8'h0F;

    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_FORMAT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_OK   = 3'd0,
        STS_ADDR = 3'd1,
        STS_KEPT = 3'd2,
        STS_LOST = 3'd3,
        STS_FAIL = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_FREE  = 2'd1,
        CLS_LIVE  = 2'd2
    } t_cls;

    typedef struct packed {
        logic       fwe;
        logic [7:0] fwd;
        logic       rwe;
        logic [7:0] rwd;
        logic       gwe;
        logic [7:0] gwd;
    } t_dp_cmd;

    typedef struct packed {
        logic [7:0] frd;
        logic [7:0] rrd;
        logic [7:0] grd;
    } t_dp_stat;

    function automatic t_cls fn_class(input logic [7:0] h);
        t_cls c;
        if (h == HDR_FREE) c = CLS_FREE;
        else if (h == HDR_LIVE) c = CLS_LIVE;
        else c = CLS_OTHER;
        return c;
    endfunction

endpackage

### src/flash_eeprom_emulation_controller.sv
// flash_eeprom_emulation_controller: two-sector flash EEPROM emulation over fee_ctrl
// and fee_dpath (fee_pkg types). One item at a time. Read: checks the live record,
// then fetches the result bytes. Write commit: copies the live record, merges the
// staged bytes and programs the next slot, plus an erase sweep on a sector change;
// a scan searches the slots; a format erases both sectors. After reset a clearing
// pass erases the image.
module flash_eeprom_emulation_controller #(
    parameter int DATA_BYTES   = 30,
    parameter int SECTOR_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_start_offset,
    input  logic [7:0]  i_byte_count,
    input  logic [7:0]  i_write_byte,
    input  logic        i_run_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_byte,
    output logic [2:0]  o_status,
    output logic        o_final_res,
    output logic [15:0] o_record_position,
    output logic        o_was_formatted
);

    localparam int REC = DATA_BYTES + 2;
    localparam int FAW = $clog2(2 * SECTOR_BYTES) + 1;
    localparam int RAW = $clog2(REC);
    localparam int GAW = $clog2(DATA_BYTES > 1 ? DATA_BYTES : 2);

    fee_pkg::t_dp_cmd  s_cmd;
    fee_pkg::t_dp_stat s_stat;
    logic [FAW-1:0] s_fa, s_fwa;
    logic [RAW-1:0] s_ra, s_rwa;
    logic [GAW-1:0] s_ga, s_gwa;

    fee_ctrl #(.DATA_BYTES(DATA_BYTES), .SECTOR_BYTES(SECTOR_BYTES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_op(i_op), .i_start_offset(i_start_offset), .i_byte_count(i_byte_count),
        .i_write_byte(i_write_byte), .i_run_end(i_run_end),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_read_byte(o_read_byte), .o_status(o_status), .o_final_res(o_final_res),
        .o_record_position(o_record_position), .o_was_formatted(o_was_formatted),
        .o_cmd(s_cmd), .o_fa(s_fa), .o_fwa(s_fwa), .o_ra(s_ra), .o_rwa(s_rwa),
        .o_ga(s_ga), .o_gwa(s_gwa), .i_stat(s_stat)
    );

    fee_dpath #(.DATA_BYTES(DATA_BYTES), .SECTOR_BYTES(SECTOR_BYTES)) u_dpath (
        .i_clk(i_clk), .i_cmd(s_cmd), .i_fa(s_fa), .i_fwa(s_fwa),
        .i_ra(s_ra), .i_rwa(s_rwa), .i_ga(s_ga), .i_gwa(s_gwa), .o_stat(s_stat)
    );

endmodule

### src/fee_dpath.sv
// fee_dpath: flash image, record buffer and staging memories with registered
// read ports. Depends on fee_pkg for the command and status structs.
module fee_dpath #(
    parameter int DATA_BYTES   = 30,
    parameter int SECTOR_BYTES = 4096,
    localparam int REC = DATA_BYTES + 2,
    localparam int IMG = 2 * SECTOR_BYTES,
    localparam int IAW = $clog2(IMG),
    localparam int FAW = IAW + 1,
    localparam int RAW = $clog2(REC),
    localparam int GAW = $clog2(DATA_BYTES > 1 ? DATA_BYTES : 2)
) (
    input  logic               i_clk,
    input  fee_pkg::t_dp_cmd   i_cmd,
    input  logic [FAW-1:0]     i_fa,
    input  logic [FAW-1:0]     i_fwa,
    input  logic [RAW-1:0]     i_ra,
    input  logic [RAW-1:0]     i_rwa,
    input  logic [GAW-1:0]     i_ga,
    input  logic [GAW-1:0]     i_gwa,
    output fee_pkg::t_dp_stat  o_stat
);

    logic [7:0] r_flash [IMG];
    logic [7:0] r_rec   [REC];
    logic [7:0] r_stage [DATA_BYTES];
    logic [7:0] r_frd;
    logic       r_foor;
    logic [7:0] r_rrd;
    logic [7:0] r_grd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fwe && (i_fwa < FAW'(IMG))) r_flash[i_fwa[IAW-1:0]] <= i_cmd.fwd;
        r_frd  <= r_flash[i_fa[IAW-1:0]];
        r_foor <= (i_fa >= FAW'(IMG));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rwe) r_rec[i_rwa] <= i_cmd.rwd;
        r_rrd <= r_rec[i_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gwe) r_stage[i_gwa] <= i_cmd.gwd;
        r_grd <= r_stage[i_ga];
    end

    assign o_stat.frd = r_foor ? fee_pkg::HDR_FREE : r_frd;
    assign o_stat.rrd = r_rrd;
    assign o_stat.grd = r_grd;

endmodule

### src/fee_ctrl.sv
// fee_ctrl: sequencer for scan, format, read, write commit, erase sweeps and
// the output register. Depends on fee_pkg; drives fee_dpath by commands.
module fee_ctrl #(
    parameter int DATA_BYTES   = 30,
    parameter int SECTOR_BYTES = 4096,
    localparam int REC = DATA_BYTES + 2,
    localparam int IMG = 2 * SECTOR_BYTES,
    localparam int IAW = $clog2(IMG),
    localparam int FAW = IAW + 1,
    localparam int RAW = $clog2(REC),
    localparam int GAW = $clog2(DATA_BYTES > 1 ? DATA_BYTES : 2)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [7:0]         i_start_offset,
    input  logic [7:0]         i_byte_count,
    input  logic [7:0]         i_write_byte,
    input  logic               i_run_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_read_byte,
    output logic [2:0]         o_status,
    output logic               o_final_res,
    output logic [15:0]        o_record_position,
    output logic               o_was_formatted,
    output fee_pkg::t_dp_cmd   o_cmd,
    output logic [FAW-1:0]     o_fa,
    output logic [FAW-1:0]     o_fwa,
    output logic [RAW-1:0]     o_ra,
    output logic [RAW-1:0]     o_rwa,
    output logic [GAW-1:0]     o_ga,
    output logic [GAW-1:0]     o_gwa,
    input  fee_pkg::t_dp_stat  i_stat
);

    localparam int SWW = $clog2(IMG + 1);
    localparam int KW  = $clog2(REC + 1);
    localparam int CW  = $clog2(DATA_BYTES + 1);
    localparam int IW  = $clog2(SECTOR_BYTES) + 1;
    localparam logic VS  = ((SECTOR_BYTES % REC) == 0);
    localparam logic VFF = (IMG > 65535) && (((65535 - 2) % REC) == 0);

    typedef enum logic [5:0] {
        ST_CLR, ST_IDLE, ST_EMIT, ST_SW, ST_FM_0, ST_FM_H,
        ST_SC_0, ST_SC_1, ST_SC_2, ST_SC_3, ST_SC_4,
        ST_SS_A, ST_SS_B, ST_SS_C, ST_SS_END, ST_SC_FND, ST_SC_OK, ST_SC_FMT,
        ST_RR_START, ST_RR_CHK, ST_RR_B, ST_RR_C, ST_RR_NEXT,
        ST_RD_A, ST_RD_B, ST_RD_C,
        ST_W_START, ST_CP_0, ST_CP_A, ST_CP_B, ST_CP_C, ST_W_CHK,
        ST_MG_A, ST_MG_B, ST_MG_C, ST_W_NXT, ST_NX_A, ST_NX_B, ST_NX_C,
        ST_CM_1, ST_CM_2, ST_CM_3, ST_W_NEXT, ST_WF_1, ST_FF, ST_WF_P,
        ST_PR_A, ST_PR_B, ST_PR_C
    } t_state;

    typedef enum logic [1:0] {
        CHG_NONE  = 2'd0,
        CHG_TO_S0 = 2'd1,
        CHG_TO_S1 = 2'd2
    } t_chg;

    t_state r_state, n_state, r_sret, n_sret, r_fret, n_fret;
    t_state r_scret, n_scret, r_pret, n_pret;
    fee_pkg::t_dp_cmd r_cmd, n_cmd;
    logic [FAW-1:0] r_fa, n_fa, r_fwa, n_fwa, r_nxt, n_nxt, r_pb, n_pb;
    logic [RAW-1:0] r_ra, n_ra, r_rwa, n_rwa;
    logic [GAW-1:0] r_ga, n_ga, r_gwa, n_gwa;
    logic [SWW-1:0] r_swn, n_swn;
    logic [1:0]     r_hk, n_hk;
    logic [15:0]    r_live, n_live, r_cur, n_cur;
    logic           r_pvalid, n_pvalid, r_fmt, n_fmt;
    logic [CW-1:0]  r_stcnt, n_stcnt;
    logic [7:0]     r_off, n_off, r_cnt, n_cnt;
    fee_pkg::t_status r_est, n_est;
    fee_pkg::t_cls  r_c1, n_c1, r_c2, n_c2, s_c2;
    logic           r_u2, n_u2, r_spass, n_spass, r_scr, n_scr, r_pass, n_pass;
    logic [IW-1:0]  r_i, n_i;
    logic [KW-1:0]  r_k, n_k, r_kend, n_kend;
    logic           r_h0live, n_h0live, r_got, n_got, r_fail, n_fail;
    t_chg           r_chg, n_chg;
    logic [7:0]     r_hv, n_hv;
    logic           r_ov, n_ov, r_ofin, n_ofin, r_ofmt, n_ofmt;
    logic [7:0]     r_obyte, n_obyte;
    fee_pkg::t_status r_ost, n_ost;
    logic [15:0]    r_opos, n_opos;

    logic           s_free, s_bad;
    logic [FAW-1:0] s_base, s_inner, s_cur;
    logic [7:0]     s_frd;

    assign s_frd  = i_stat.frd;
    assign s_free = !r_ov || i_out_ready;
    assign s_bad  = ({1'b0, i_start_offset} + {1'b0, i_byte_count} > 9'(DATA_BYTES))
                    || (i_start_offset >= 8'(DATA_BYTES))
                    || (i_byte_count > 8'(DATA_BYTES));
    assign s_base = r_u2 ? FAW'(SECTOR_BYTES) : '0;
    assign s_cur  = FAW'(r_cur);
    assign s_inner = (s_cur >= FAW'(SECTOR_BYTES)) ? s_cur - FAW'(SECTOR_BYTES) : s_cur;
    assign s_c2   = fee_pkg::fn_class(s_frd);

    always_comb begin
        n_state = r_state; n_sret = r_sret; n_fret = r_fret; n_scret = r_scret;
        n_pret = r_pret;
        n_cmd = r_cmd; n_cmd.fwe = 1'b0; n_cmd.rwe = 1'b0; n_cmd.gwe = 1'b0;
        n_fa = r_fa; n_fwa = r_fwa; n_nxt = r_nxt; n_pb = r_pb;
        n_ra = r_ra; n_rwa = r_rwa; n_ga = r_ga; n_gwa = r_gwa;
        n_swn = r_swn; n_hk = r_hk; n_live = r_live; n_cur = r_cur;
        n_pvalid = r_pvalid; n_fmt = r_fmt; n_stcnt = r_stcnt;
        n_off = r_off; n_cnt = r_cnt; n_est = r_est; n_c1 = r_c1; n_c2 = r_c2;
        n_u2 = r_u2; n_spass = r_spass; n_scr = r_scr; n_pass = r_pass;
        n_i = r_i; n_k = r_k; n_kend = r_kend; n_h0live = r_h0live;
        n_got = r_got; n_fail = r_fail; n_chg = r_chg; n_hv = r_hv;
        n_ov = r_ov && !i_out_ready; n_ofin = r_ofin; n_ofmt = r_ofmt;
        n_obyte = r_obyte; n_ost = r_ost; n_opos = r_opos;

        unique case (r_state)
            ST_CLR: begin
                n_fa = '0; n_swn = SWW'(IMG); n_sret = ST_IDLE; n_state = ST_SW;
            end
            ST_SW: begin
                n_cmd.fwe = 1'b1; n_fwa = r_fa; n_cmd.fwd = fee_pkg::HDR_FREE;
                n_fa = r_fa + FAW'(1); n_swn = r_swn - SWW'(1);
                if (r_swn == SWW'(1)) n_state = r_sret;
            end
            ST_FM_0: begin
                n_fa = '0; n_swn = SWW'(IMG); n_sret = ST_FM_H; n_hk = '0;
                n_state = ST_SW;
            end
            ST_FM_H: begin
                n_cmd.fwe = 1'b1; n_fwa = FAW'(r_hk); n_cmd.fwd = fee_pkg::HDR_LIVE;
                n_hk = r_hk + 2'd1;
                if (r_hk == 2'd3) begin
                    n_live = 16'd2; n_pvalid = 1'b1; n_fmt = 1'b1; n_state = r_fret;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_fmt = 1'b0; n_off = i_start_offset; n_cnt = i_byte_count;
                    if (fee_pkg::t_op'(i_op) != fee_pkg::OP_WRITE) n_stcnt = '0;
                    unique case (fee_pkg::t_op'(i_op))
                        fee_pkg::OP_SCAN: begin
                            n_live = 16'hFFFF; n_pvalid = VFF; n_scret = ST_EMIT;
                            n_est = fee_pkg::STS_OK; n_state = ST_SC_0;
                        end
                        fee_pkg::OP_FORMAT: begin
                            n_fret = ST_EMIT; n_est = fee_pkg::STS_OK; n_state = ST_FM_0;
                        end
                        fee_pkg::OP_READ: begin
                            if (s_bad) begin
                                n_est = fee_pkg::STS_ADDR; n_state = ST_EMIT;
                            end else begin
                                n_pass = 1'b0; n_state = ST_RR_START;
                            end
                        end
                        fee_pkg::OP_WRITE: begin
                            if (r_stcnt < CW'(DATA_BYTES)) begin
                                n_cmd.gwe = 1'b1; n_gwa = r_stcnt[GAW-1:0];
                                n_cmd.gwd = i_write_byte; n_stcnt = r_stcnt + CW'(1);
                            end
                            if (i_run_end) begin
                                n_stcnt = '0;
                                if (s_bad) begin
                                    n_est = fee_pkg::STS_ADDR; n_state = ST_EMIT;
                                end else begin
                                    n_pass = 1'b0; n_state = ST_W_START;
                                end
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EMIT: begin
                if (s_free) begin
                    n_ov = 1'b1; n_obyte = '0; n_ost = r_est; n_ofin = 1'b1;
                    n_opos = r_live; n_ofmt = r_fmt; n_state = ST_IDLE;
                end
            end
            ST_SC_0: begin n_fa = '0; n_state = ST_SC_1; end
            ST_SC_1: n_state = ST_SC_2;
            ST_SC_2: begin
                n_c1 = fee_pkg::fn_class(s_frd); n_fa = FAW'(SECTOR_BYTES);
                n_state = ST_SC_3;
            end
            ST_SC_3: n_state = ST_SC_4;
            ST_SC_4: begin
                n_c2 = s_c2; n_i = IW'(2); n_spass = 1'b0;
                if (s_c2 == fee_pkg::CLS_LIVE) begin
                    n_u2 = 1'b1; n_state = ST_SS_A;
                end else if (r_c1 == fee_pkg::CLS_LIVE) begin
                    n_u2 = 1'b0; n_state = ST_SS_A;
                end else begin
                    n_fret = ST_SC_FMT; n_state = ST_FM_0;
                end
            end
            ST_SS_A: begin
                if (r_i >= IW'(SECTOR_BYTES)) n_state = ST_SS_END;
                else begin
                    n_fa = s_base + FAW'(r_i); n_state = ST_SS_B;
                end
            end
            ST_SS_B: n_state = ST_SS_C;
            ST_SS_C: begin
                if (s_frd == fee_pkg::HDR_LIVE) begin
                    n_live = 16'(s_base + FAW'(r_i));
                    n_pvalid = r_u2 ? VS : 1'b1;
                    n_state = ST_SC_FND;
                end else begin
                    n_i = r_i + IW'(REC); n_state = ST_SS_A;
                end
            end
            ST_SS_END: begin
                if (!r_spass && r_u2 && (r_c1 == fee_pkg::CLS_LIVE)) begin
                    n_u2 = 1'b0; n_spass = 1'b1; n_i = IW'(2); n_state = ST_SS_A;
                end else begin
                    n_fret = ST_SC_FMT; n_state = ST_FM_0;
                end
            end
            ST_SC_FND: begin
                n_swn = SWW'(SECTOR_BYTES); n_sret = ST_SC_OK;
                if (!r_u2 && (r_c2 != fee_pkg::CLS_FREE)) begin
                    n_fa = FAW'(SECTOR_BYTES); n_state = ST_SW;
                end else if (r_u2 && (r_c1 != fee_pkg::CLS_FREE)) begin
                    n_fa = '0; n_state = ST_SW;
                end else begin
                    n_state = ST_SC_OK;
                end
            end
            ST_SC_OK: begin n_scr = 1'b0; n_state = r_scret; end
            ST_SC_FMT: begin n_scr = 1'b1; n_state = r_scret; end
            ST_RR_START: begin
                if (!r_pvalid) begin
                    n_scret = ST_RR_CHK; n_state = ST_SC_0;
                end else begin
                    n_scr = 1'b0; n_state = ST_RR_CHK;
                end
            end
            ST_RR_CHK: begin
                if (r_scr) begin
                    n_scret = ST_RR_NEXT; n_state = ST_SC_0;
                end else begin
                    n_fa = FAW'(r_live); n_state = ST_RR_B;
                end
            end
            ST_RR_B: n_state = ST_RR_C;
            ST_RR_C: begin
                if (s_frd == fee_pkg::HDR_LIVE) begin
                    n_k = '0; n_est = fee_pkg::STS_OK;
                    n_state = (r_cnt == 8'd0) ? ST_EMIT : ST_RD_A;
                end else begin
                    n_scret = ST_RR_NEXT; n_state = ST_SC_0;
                end
            end
            ST_RR_NEXT: begin
                if (r_pass) begin
                    n_est = fee_pkg::STS_FAIL; n_state = ST_EMIT;
                end else begin
                    n_pass = 1'b1; n_state = ST_RR_START;
                end
            end
            ST_RD_A: begin
                n_fa = FAW'(r_live) + FAW'(2) + FAW'(r_off) + FAW'(r_k);
                n_state = ST_RD_B;
            end
            ST_RD_B: n_state = ST_RD_C;
            ST_RD_C: begin
                if (s_free) begin
                    n_ov = 1'b1; n_obyte = s_frd; n_ost = fee_pkg::STS_OK;
                    n_ofin = (8'(r_k) + 8'd1 == r_cnt); n_opos = r_live; n_ofmt = r_fmt;
                    n_k = r_k + KW'(1);
                    n_state = (8'(r_k) + 8'd1 == r_cnt) ? ST_IDLE : ST_RD_A;
                end
            end
            ST_W_START: begin
                n_got = 1'b0;
                if (!r_pvalid) begin
                    n_scret = ST_CP_0; n_state = ST_SC_0;
                end else begin
                    n_state = ST_CP_0;
                end
            end
            ST_CP_0: begin n_cur = r_live; n_k = '0; n_state = ST_CP_A; end
            ST_CP_A: begin n_fa = s_cur + FAW'(r_k); n_state = ST_CP_B; end
            ST_CP_B: n_state = ST_CP_C;
            ST_CP_C: begin
                n_cmd.rwe = 1'b1; n_rwa = r_k[RAW-1:0]; n_cmd.rwd = s_frd;
                if (r_k == '0) n_h0live = (s_frd == fee_pkg::HDR_LIVE);
                n_k = r_k + KW'(1);
                n_state = (r_k == KW'(REC - 1)) ? ST_W_CHK : ST_CP_A;
            end
            ST_W_CHK: begin
                n_k = '0; n_fail = 1'b0;
                if (r_h0live) begin
                    n_got = 1'b1;
                    n_state = (r_cnt == 8'd0) ? ST_W_NXT : ST_MG_A;
                end else begin
                    n_scret = ST_W_NEXT; n_state = ST_SC_0;
                end
            end
            ST_MG_A: begin n_ga = r_k[GAW-1:0]; n_state = ST_MG_B; end
            ST_MG_B: n_state = ST_MG_C;
            ST_MG_C: begin
                n_cmd.rwe = 1'b1; n_cmd.rwd = i_stat.grd;
                n_rwa = RAW'(8'd2 + r_off + 8'(r_k));
                n_k = r_k + KW'(1);
                if (8'(r_k) + 8'd1 == r_cnt) n_state = r_fail ? ST_WF_P : ST_W_NXT;
                else n_state = ST_MG_A;
            end
            ST_W_NXT: begin
                if (s_inner + FAW'(2 * REC) < FAW'(SECTOR_BYTES)) begin
                    n_chg = CHG_NONE; n_nxt = s_cur + FAW'(REC);
                end else if (s_cur >= FAW'(SECTOR_BYTES)) begin
                    n_chg = CHG_TO_S0; n_nxt = FAW'(2);
                end else begin
                    n_chg = CHG_TO_S1; n_nxt = FAW'(2 + SECTOR_BYTES);
                end
                n_state = ST_NX_A;
            end
            ST_NX_A: begin n_fa = r_nxt; n_state = ST_NX_B; end
            ST_NX_B: n_state = ST_NX_C;
            ST_NX_C: begin
                if (s_frd == fee_pkg::HDR_FREE) begin
                    n_live = 16'(r_nxt);
                    if (r_chg == CHG_TO_S0) n_pvalid = 1'b1;
                    else if (r_chg == CHG_TO_S1) n_pvalid = VS;
                    n_pb = r_nxt; n_k = '0; n_kend = KW'(REC); n_hv = fee_pkg::HDR_LIVE;
                    n_pret = ST_CM_1; n_state = ST_PR_A;
                end else begin
                    n_scret = ST_W_NEXT; n_state = ST_SC_0;
                end
            end
            ST_CM_1: begin
                n_k = '0; n_kend = KW'(2); n_hv = fee_pkg::HDR_LIVE; n_pret = ST_CM_2;
                n_pb = (r_chg == CHG_TO_S0) ? '0 : FAW'(SECTOR_BYTES);
                n_state = (r_chg != CHG_NONE) ? ST_PR_A : ST_CM_2;
            end
            ST_CM_2: begin
                n_pb = s_cur; n_k = '0; n_kend = KW'(2); n_hv = fee_pkg::HDR_RETIRED;
                n_pret = ST_CM_3; n_state = ST_PR_A;
            end
            ST_CM_3: begin
                n_est = fee_pkg::STS_OK; n_swn = SWW'(SECTOR_BYTES); n_sret = ST_EMIT;
                n_fa = (r_chg == CHG_TO_S0) ? FAW'(SECTOR_BYTES) : '0;
                n_state = (r_chg != CHG_NONE) ? ST_SW : ST_EMIT;
            end
            ST_W_NEXT: begin
                if (r_pass) begin
                    n_fret = ST_WF_1; n_state = ST_FM_0;
                end else begin
                    n_pass = 1'b1; n_state = ST_W_START;
                end
            end
            ST_WF_1: begin
                n_k = '0; n_fail = 1'b1;
                if (!r_got) n_state = ST_FF;
                else n_state = (r_cnt == 8'd0) ? ST_WF_P : ST_MG_A;
            end
            ST_FF: begin
                n_cmd.rwe = 1'b1; n_rwa = r_k[RAW-1:0]; n_cmd.rwd = fee_pkg::HDR_FREE;
                n_k = r_k + KW'(1);
                if (r_k == KW'(REC - 1)) begin
                    n_k = '0; n_state = (r_cnt == 8'd0) ? ST_WF_P : ST_MG_A;
                end
            end
            ST_WF_P: begin
                n_pb = FAW'(2); n_k = KW'(2); n_kend = KW'(REC); n_pret = ST_EMIT;
                n_est = r_got ? fee_pkg::STS_KEPT : fee_pkg::STS_LOST;
                n_state = ST_PR_A;
            end
            ST_PR_A: begin
                n_fa = r_pb + FAW'(r_k); n_ra = r_k[RAW-1:0]; n_state = ST_PR_B;
            end
            ST_PR_B: n_state = ST_PR_C;
            ST_PR_C: begin
                n_cmd.fwe = 1'b1; n_fwa = r_fa;
                n_cmd.fwd = s_frd & ((r_k < KW'(2)) ? r_hv : i_stat.rrd);
                n_k = r_k + KW'(1);
                n_state = (r_k + KW'(1) == r_kend) ? r_pret : ST_PR_A;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR; r_ov <= 1'b0; r_live <= 16'hFFFF; r_pvalid <= VFF;
            r_fmt <= 1'b0; r_stcnt <= '0; r_cmd <= '0;
        end else begin
            r_state <= n_state; r_ov <= n_ov; r_live <= n_live; r_pvalid <= n_pvalid;
            r_fmt <= n_fmt; r_stcnt <= n_stcnt; r_cmd <= n_cmd;
        end
        r_sret <= n_sret; r_fret <= n_fret; r_scret <= n_scret; r_pret <= n_pret;
        r_fa <= n_fa; r_fwa <= n_fwa; r_nxt <= n_nxt; r_pb <= n_pb;
        r_ra <= n_ra; r_rwa <= n_rwa; r_ga <= n_ga; r_gwa <= n_gwa;
        r_swn <= n_swn; r_hk <= n_hk; r_cur <= n_cur;
        r_off <= n_off; r_cnt <= n_cnt; r_est <= n_est; r_c1 <= n_c1; r_c2 <= n_c2;
        r_u2 <= n_u2; r_spass <= n_spass; r_scr <= n_scr; r_pass <= n_pass;
        r_i <= n_i; r_k <= n_k; r_kend <= n_kend; r_h0live <= n_h0live;
        r_got <= n_got; r_fail <= n_fail; r_chg <= n_chg; r_hv <= n_hv;
        r_ofin <= n_ofin; r_ofmt <= n_ofmt; r_obyte <= n_obyte; r_ost <= n_ost;
        r_opos <= n_opos;
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_out_valid       = r_ov;
    assign o_read_byte       = r_obyte;
    assign o_status          = r_ost;
    assign o_final_res       = r_ofin;
    assign o_record_position = r_opos;
    assign o_was_formatted   = r_ofmt;
    assign o_cmd = r_cmd;
    assign o_fa  = r_fa;
    assign o_fwa = r_fwa;
    assign o_ra  = r_ra;
    assign o_rwa = r_rwa;
    assign o_ga  = r_ga;
    assign o_gwa = r_gwa;

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.fwe |-> (r_fwa < FAW'(IMG)))
        else $error("flash write outside image");
    a_stcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stcnt <= CW'(DATA_BYTES))
        else $error("staging count overflow");
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvalid |-> (r_live >= 16'd2 && FAW'(r_live) < FAW'(IMG)))
        else $error("valid record position out of range");
    a_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SW) |-> (r_swn != '0))
        else $error("erase sweep with zero length");

endmodule
